/* rtl/core/ncd_pkg.sv */
// ----------------------------------------------------------------------------
// ncd_pkg
// Shared types, sizes and constants of the negative cycle detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ncd_pkg;

    // capacities
    localparam int MAX_VERTICES = 512;
    localparam int MAX_EDGES    = 8192;

    // field widths
    localparam int VERT_FW  = 9;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 32;
    localparam int VC_W     = 9;

    // storage address and count widths
    localparam int VERT_AW = $clog2(MAX_VERTICES);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int EDGE_CW = $clog2(MAX_EDGES + 1);

    // distance start value and saturation floor
    localparam logic [DIST_W-1:0] DIST_INIT = {4{8'h3f}};
    localparam logic [DIST_W-1:0] DIST_MIN  = {1'b1, {(DIST_W-1){1'b0}}};

    // input word
    typedef struct packed {
        logic [VERT_FW-1:0]         edge_source;
        logic [VERT_FW-1:0]         edge_dest;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       both_ways;
        logic                       last_edge;
    } t_edge_word;

    // result word
    typedef struct packed {
        logic negative_cycle;
        logic edges_dropped;
    } t_result_word;

    // one entry of the edge store
    typedef struct packed {
        logic [VERT_FW-1:0]         src;
        logic [VERT_FW-1:0]         dst;
        logic signed [WEIGHT_W-1:0] weight;
    } t_edge_entry;

    // controller states
    typedef enum logic [2:0] {
        S_LOAD,
        S_REVERSE,
        S_INIT,
        S_EDGE_RD,
        S_DIST_RD,
        S_UPDATE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_fwd;
        logic load_rev;
        logic init_step;
        logic update;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic item_last;
        logic init_last;
        logic no_edges;
        logic checking;
        logic lower;
        logic edge_last;
        logic out_free;
    } t_status;

    // vertex index within the distance store
    function automatic logic vertex_ok(input logic [VERT_FW-1:0] v);
        return 32'(v) < 32'(MAX_VERTICES);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ncd_ram.sv */
// ----------------------------------------------------------------------------
// ncd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ncd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/ncd_ctrl.sv */
// ----------------------------------------------------------------------------
// ncd_ctrl
// Sequencer: edge loading, distance sweep, relaxation passes, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ncd_ctrl
    import ncd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_both,
    input  wire logic    i_in_last,
    input  wire t_status i_status,
    output      logic    o_in_ready,
    output      t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (i_in_both) begin
                        n_state = S_REVERSE;
                    end else if (i_in_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_REVERSE: begin
                n_state = i_status.item_last ? S_INIT : S_LOAD;
            end
            S_INIT: begin
                if (i_status.init_last) begin
                    n_state = i_status.no_edges ? S_DONE : S_EDGE_RD;
                end
            end
            S_EDGE_RD: begin
                n_state = S_DIST_RD;
            end
            S_DIST_RD: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.checking && i_status.lower) begin
                    n_state = S_DONE;
                end else if (i_status.edge_last && i_status.checking) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EDGE_RD;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready     = 1'b1;
                o_cmd.load_fwd = i_in_valid;
            end
            S_REVERSE: begin
                o_cmd.load_rev = 1'b1;
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/ncd_datapath.sv */
// ----------------------------------------------------------------------------
// ncd_datapath
// Edge store, distance store, counters, relax compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncd_datapath
    import ncd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [VC_W-1:0]   i_cfg_data,
    input  wire t_edge_word        i_in_word,
    input  wire t_cmd              i_cmd,
    output      t_status           o_status,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      t_result_word      o_out_word
);

    // control registers
    logic [VC_W-1:0]    r_vertex_count;
    logic [EDGE_CW-1:0] r_count;
    logic               r_overflow;
    logic [EDGE_AW-1:0] r_edge_idx;
    logic [VC_W-1:0]    r_pass;
    logic [VERT_AW-1:0] r_init_idx;
    logic               r_out_valid;
    logic               r_neg_found;

    // payload registers
    t_edge_word         r_item;
    t_result_word       r_result;

    // store ports
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_waddr;
    t_edge_entry        edge_wdata;
    logic [$bits(t_edge_entry)-1:0] edge_rdata;
    t_edge_entry        edge_q;

    logic               dist_we;
    logic [VERT_AW-1:0] dist_waddr;
    logic [DIST_W-1:0]  dist_wdata;
    logic [DIST_W-1:0]  dist_src_q;
    logic [DIST_W-1:0]  dist_dst_q;

    // compare path
    logic               store_full;
    logic [VC_W-1:0]    passes;
    logic               checking;
    logic               edge_last;
    logic               edge_valid;
    logic signed [DIST_W:0] cand;
    logic               lower;
    logic [DIST_W-1:0]  relaxed;
    logic               out_free;

    assign store_full = (r_count == EDGE_CW'(MAX_EDGES));
    assign passes     = (r_vertex_count == '0) ? '0 : r_vertex_count - VC_W'(1);
    assign checking   = (r_pass == passes);
    assign edge_last  = (EDGE_CW'(r_edge_idx) + EDGE_CW'(1) == r_count);
    assign out_free   = !r_out_valid || i_out_ready;

    // edge store write: forward edge from the port, reverse from the held word
    always_comb begin
        edge_we    = 1'b0;
        edge_waddr = r_count[EDGE_AW-1:0];
        edge_wdata = '{src: i_in_word.edge_source, dst: i_in_word.edge_dest,
                       weight: i_in_word.edge_weight};
        if (i_cmd.load_fwd) begin
            edge_we = !store_full;
        end else if (i_cmd.load_rev) begin
            edge_we    = !store_full;
            edge_wdata = '{src: r_item.edge_dest, dst: r_item.edge_source,
                           weight: r_item.edge_weight};
        end
    end

    ncd_ram #(
        .WIDTH ($bits(t_edge_entry)),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (r_edge_idx),
        .o_rdata (edge_rdata)
    );

    assign edge_q = t_edge_entry'(edge_rdata);

    // relax compare on exact sum, floor at the signed minimum
    assign edge_valid = vertex_ok(edge_q.src) && vertex_ok(edge_q.dst);
    assign cand       = (DIST_W+1)'($signed(dist_src_q)) + (DIST_W+1)'(edge_q.weight);
    assign lower      = edge_valid && (cand < (DIST_W+1)'($signed(dist_dst_q)));
    assign relaxed    = (cand[DIST_W] && !cand[DIST_W-1]) ? DIST_MIN : cand[DIST_W-1:0];

    // distance write: start sweep or relaxed value
    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = VERT_AW'(edge_q.dst);
        dist_wdata = relaxed;
        if (i_cmd.init_step) begin
            dist_we    = 1'b1;
            dist_waddr = r_init_idx;
            dist_wdata = (r_init_idx == '0) ? '0 : DIST_INIT;
        end else if (i_cmd.update && !checking && lower) begin
            dist_we = 1'b1;
        end
    end

    // two copies so source and destination are read in the same cycle
    ncd_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_src_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (VERT_AW'(edge_q.src)),
        .o_rdata (dist_src_q)
    );

    ncd_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_dst_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (VERT_AW'(edge_q.dst)),
        .o_rdata (dist_dst_q)
    );

    // vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VC_W'(1);
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.finish) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.load_fwd || i_cmd.load_rev) begin
            if (store_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + EDGE_CW'(1);
            end
        end
    end

    // held input word for the reverse edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fwd) begin
            r_item <= i_in_word;
        end
    end

    // sweep, edge and pass counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_idx <= '0;
            r_edge_idx <= '0;
            r_pass     <= '0;
        end else if (i_cmd.init_step) begin
            r_init_idx <= r_init_idx + VERT_AW'(1);
            r_edge_idx <= '0;
            r_pass     <= '0;
        end else if (i_cmd.update) begin
            if (edge_last) begin
                r_edge_idx <= '0;
                if (!checking) begin
                    r_pass <= r_pass + VC_W'(1);
                end
            end else begin
                r_edge_idx <= r_edge_idx + EDGE_AW'(1);
            end
        end else if (i_cmd.finish) begin
            r_pass <= '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // verdict of the running graph, moved into the result word at hand-off
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_step) begin
            r_neg_found <= 1'b0;
        end else if (i_cmd.update && checking && lower) begin
            r_neg_found <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_result.negative_cycle <= r_neg_found;
            r_result.edges_dropped  <= r_overflow;
        end
    end

    // status back to the sequencer
    always_comb begin
        o_status.item_last = r_item.last_edge;
        o_status.init_last = (r_init_idx == VERT_AW'(MAX_VERTICES - 1));
        o_status.no_edges  = (r_count == '0);
        o_status.checking  = checking;
        o_status.lower     = lower;
        o_status.edge_last = edge_last;
        o_status.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_result;

endmodule

`default_nettype wire

/* rtl/core/negative_cycle_detector.sv */
// Loading: one edge word a cycle, stalled after a two-way edge (single store write port).
// Compute after the last word: a distance sweep over all MAX_VERTICES entries, then per
//   stored edge per pass an edge read, distance read, and compare and write, in at most
//   passes + 1; the check pass stops at the first edge that still lowers a distance.
// Result word: registered from the done state once output is free; input stalls meanwhile.
// Reset clears the fill count, overflow flag, counters and output valid; the edge store
//   needs no clearing pass and the distance store is swept at each computation start.
// ----------------------------------------------------------------------------
// negative_cycle_detector
// Bellman-Ford negative cycle detector over an edge list loaded word by word.
// ----------------------------------------------------------------------------
`default_nettype none

module negative_cycle_detector
    import ncd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [VC_W-1:0] i_cfg_data,
    input  wire logic            i_in_valid,
    output      logic            o_in_ready,
    input  wire t_edge_word      i_in_word,
    output      logic            o_out_valid,
    input  wire logic            i_out_ready,
    output      t_result_word    o_out_word
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    ncd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_both  (i_in_word.both_ways),
        .i_in_last  (i_in_word.last_edge),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // stores and arithmetic
    ncd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

/* rtl/core/ncd_checker.sv */
// ----------------------------------------------------------------------------
// ncd_checker
// Port-level checks of the negative cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ncd_checker
    import ncd_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_cfg_we,
    input wire logic [VC_W-1:0] i_cfg_data,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire t_edge_word      i_in_word,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire t_result_word    o_out_word
);

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // reset leaves the block empty and ready to load
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty and ready after reset");

    // a last word ends loading
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.last_edge |=> !o_in_ready)
        else $error("input still taken after the last edge word");

    // a new result only comes out of a computation
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result raised while loading");

endmodule

bind negative_cycle_detector ncd_checker u_ncd_checker (.*);

`default_nettype wire
